// ===== hdl/e2r_pkg.sv =====
// Package for the Euler angle to rotation matrix block: item types, widths
// and the CORDIC arc table. No dependencies.
package e2r_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int FRACTION_BITS = 14;
    localparam int OUT_BITS      = FRACTION_BITS + 2;
    localparam int CORDIC_STEPS  = 30;

    localparam logic signed [34:0] CORDIC_GAIN = 35'sd2608131496;

    localparam logic signed [31:0] ARC_TABLE [0:CORDIC_STEPS-1] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81,
        32'sd41,        32'sd20,        32'sd10,        32'sd5,
        32'sd3,         32'sd1
    };

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] angle_x;
        logic signed [ANGLE_BITS-1:0] angle_y;
        logic signed [ANGLE_BITS-1:0] angle_z;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] row0_col0;
        logic signed [OUT_BITS-1:0] row0_col1;
        logic signed [OUT_BITS-1:0] row0_col2;
        logic signed [OUT_BITS-1:0] row1_col0;
        logic signed [OUT_BITS-1:0] row1_col1;
        logic signed [OUT_BITS-1:0] row1_col2;
        logic signed [OUT_BITS-1:0] row2_col0;
        logic signed [OUT_BITS-1:0] row2_col1;
        logic signed [OUT_BITS-1:0] row2_col2;
    } out_item_t;

endpackage

// ===== hdl/euler_to_rotation_matrix.sv =====
// Euler X-Y-Z angles to rotation matrix: three CORDIC lanes, product stages.
// Depends on e2r_pkg.
// Stages: one prep stage, one stage per CORDIC step over 30 steps,
// map, two multiply stages, sum.
// Throughput: one item per cycle; the whole pipe holds while the output
// register is full and not taken.
// Reset: rst_n clears only the stage valid bits; data registers are free.
module euler_to_rotation_matrix
    import e2r_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int NS   = CORDIC_STEPS;
    localparam int LAST = NS + 4;
    localparam int PW   = 66;
    localparam int SW   = 70;

    logic en;
    logic [LAST:0] vld_reg;

    logic signed [34:0] x_reg [0:NS][0:2];
    logic signed [34:0] y_reg [0:NS][0:2];
    logic signed [31:0] z_reg [0:NS][0:2];
    logic [1:0]         q_reg [0:NS][0:2];

    logic signed [32:0] cos_reg [0:2];
    logic signed [32:0] sin_reg [0:2];

    logic signed [PW-1:0] sxcz_reg, cxcz_reg, sxsz_reg, cxsz_reg;
    logic signed [PW-1:0] cycz_reg, cysz_reg, cysx_reg, cycx_reg;
    logic signed [32:0]   sy1_reg;

    logic signed [SW-1:0] t01_reg, t02_reg, t11_reg, t12_reg;
    logic signed [PW-1:0] cxsz2_reg, sxsz2_reg, cxcz2_reg, sxcz2_reg;
    logic signed [PW-1:0] cycz2_reg, cysz2_reg, cysx2_reg, cycx2_reg;
    logic signed [32:0]   sy2_reg;

    out_item_t out_reg;

    logic [ANGLE_BITS-1:0] ang [0:2];

    // Hold the whole pipe while the result waits
    assign en        = ~vld_reg[LAST] | out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LAST];
    assign out_data  = out_reg;

    assign ang[0] = in_data.angle_x;
    assign ang[1] = in_data.angle_y;
    assign ang[2] = in_data.angle_z;

    // Advance the valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAST-1:0], in_valid};
        end
    end

    // Fold the angle to a quadrant and a residue, seed the CORDIC
    for (genvar l = 0; l < 3; l++)
    begin : g_prep
        logic [31:0] u;
        logic [1:0]  q;
        assign u = {ang[l], {(32 - ANGLE_BITS){1'b0}}};
        assign q = 2'((u + 32'h2000_0000) >> 30);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[0][l] <= q;
                z_reg[0][l] <= signed'(u - {q, 30'd0});
                x_reg[0][l] <= CORDIC_GAIN;
                y_reg[0][l] <= '0;
            end
        end
    end

    // One CORDIC rotation step per stage
    for (genvar k = 0; k < NS; k++)
    begin : g_step
        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic signed [34:0] dx, dy;
            assign dx = y_reg[k][l] >>> k;
            assign dy = x_reg[k][l] >>> k;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg[k+1][l] <= q_reg[k][l];
                    if (!z_reg[k][l][31])
                    begin
                        x_reg[k+1][l] <= x_reg[k][l] - dx;
                        y_reg[k+1][l] <= y_reg[k][l] + dy;
                        z_reg[k+1][l] <= z_reg[k][l] - ARC_TABLE[k];
                    end
                    else
                    begin
                        x_reg[k+1][l] <= x_reg[k][l] + dx;
                        y_reg[k+1][l] <= y_reg[k][l] - dy;
                        z_reg[k+1][l] <= z_reg[k][l] + ARC_TABLE[k];
                    end
                end
            end
        end
    end

    // Round to scale 2^30 and map back by quadrant
    for (genvar l = 0; l < 3; l++)
    begin : g_map
        logic signed [34:0] cr, sr;
        logic signed [32:0] c, s;
        assign cr = (x_reg[NS][l] + 35'sd2) >>> 2;
        assign sr = (y_reg[NS][l] + 35'sd2) >>> 2;
        assign c  = cr[32:0];
        assign s  = sr[32:0];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                case (q_reg[NS][l])
                    2'd0:
                    begin
                        cos_reg[l] <= c;
                        sin_reg[l] <= s;
                    end
                    2'd1:
                    begin
                        cos_reg[l] <= -s;
                        sin_reg[l] <= c;
                    end
                    2'd2:
                    begin
                        cos_reg[l] <= -c;
                        sin_reg[l] <= -s;
                    end
                    default:
                    begin
                        cos_reg[l] <= s;
                        sin_reg[l] <= -c;
                    end
                endcase
            end
        end
    end

    // Pairwise products at scale 2^60
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sxcz_reg <= PW'(sin_reg[0] * cos_reg[2]);
            cxcz_reg <= PW'(cos_reg[0] * cos_reg[2]);
            sxsz_reg <= PW'(sin_reg[0] * sin_reg[2]);
            cxsz_reg <= PW'(cos_reg[0] * sin_reg[2]);
            cycz_reg <= PW'(cos_reg[1] * cos_reg[2]);
            cysz_reg <= PW'(cos_reg[1] * sin_reg[2]);
            cysx_reg <= PW'(cos_reg[1] * sin_reg[0]);
            cycx_reg <= PW'(cos_reg[1] * cos_reg[0]);
            sy1_reg  <= sin_reg[1];
        end
    end

    // Round the X-Z pairs back to 2^30 and scale by sin y
    function automatic logic signed [35:0] rnd30(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        t = (v + (PW'(1) <<< 29)) >>> 30;
        return t[35:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t01_reg   <= SW'(sy1_reg * rnd30(sxcz_reg));
            t02_reg   <= SW'(sy1_reg * rnd30(cxcz_reg));
            t11_reg   <= SW'(sy1_reg * rnd30(sxsz_reg));
            t12_reg   <= SW'(sy1_reg * rnd30(cxsz_reg));
            cxsz2_reg <= cxsz_reg;
            sxsz2_reg <= sxsz_reg;
            cxcz2_reg <= cxcz_reg;
            sxcz2_reg <= sxcz_reg;
            cycz2_reg <= cycz_reg;
            cysz2_reg <= cysz_reg;
            cysx2_reg <= cysx_reg;
            cycx2_reg <= cycx_reg;
            sy2_reg   <= sy1_reg;
        end
    end

    // Round to the output fraction and saturate to +-1.0
    function automatic logic signed [OUT_BITS-1:0] finish(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        logic signed [SW-1:0] one;
        one = SW'(1) <<< FRACTION_BITS;
        r   = (v + (SW'(1) <<< (59 - FRACTION_BITS))) >>> (60 - FRACTION_BITS);
        if (r > one)
        begin
            r = one;
        end
        if (r < -one)
        begin
            r = -one;
        end
        return r[OUT_BITS-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.row0_col0 <= finish(SW'(cycz2_reg));
            out_reg.row0_col1 <= finish(t01_reg - SW'(cxsz2_reg));
            out_reg.row0_col2 <= finish(t02_reg + SW'(sxsz2_reg));
            out_reg.row1_col0 <= finish(SW'(cysz2_reg));
            out_reg.row1_col1 <= finish(t11_reg + SW'(cxcz2_reg));
            out_reg.row1_col2 <= finish(t12_reg - SW'(sxcz2_reg));
            out_reg.row2_col0 <= finish(-(SW'(sy2_reg) <<< 30));
            out_reg.row2_col1 <= finish(SW'(cysx2_reg));
            out_reg.row2_col2 <= finish(SW'(cycx2_reg));
        end
    end

endmodule

// ===== hdl/e2r_checker.sv =====
// Port-level checks for euler_to_rotation_matrix, bound to the top level.
// Depends on e2r_pkg.
module e2r_checker
    import e2r_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    localparam logic signed [OUT_BITS-1:0] ONE = OUT_BITS'(1) << FRACTION_BITS;

    // Hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled output item changed");

    // Take input exactly when the output side can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready disagrees with output state");

    // Keep the checked matrix entries (row0_col0, row1_col1, row2_col0) within +-1.0
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.row0_col0 <= ONE) && (out_data.row0_col0 >= -ONE)
                   && (out_data.row1_col1 <= ONE) && (out_data.row1_col1 >= -ONE)
                   && (out_data.row2_col0 <= ONE) && (out_data.row2_col0 >= -ONE))
        else $error("matrix entry beyond unit range");

    // No result during reset
    a_reset: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind euler_to_rotation_matrix e2r_checker u_e2r_checker (.*);
